### rtl/lsra_pkg.sv
// Package with the types and constants of the register allocator.
`default_nettype none
package lsra_pkg;
  localparam int INT_POOL_SIZE_D      = 18;
  localparam int FLOAT_POOL_SIZE_D    = 22;
  localparam int INT_CALLEE_FIRST_D   = 7;
  localparam int FLOAT_CALLEE_FIRST_D = 10;
  localparam int ACTIVE_DEPTH_D       = 40;
  localparam int MAX_INTERVALS_D      = 4096;
  localparam int MASK_W               = 22;
  localparam int ID_W                 = 12;
  localparam int PT_W                 = 16;
  localparam int SLOT_W               = 5;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PT_W-1:0]   fin;
    logic              cls;
    logic [SLOT_W-1:0] slot;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_EXPIRE,
    ST_SEARCH,
    ST_EVICT,
    ST_INSERT,
    ST_OUT
  } state_t;

  // Command broadcast to every cell of the active row.
  typedef struct packed {
    logic   clear;
    logic   shift;
    logic   evict;
    logic   insert;
    entry_t ins;
  } cell_cmd_t;
endpackage
`default_nettype wire

### rtl/linear_scan_register_allocator.sv
// Top level of the linear-scan register allocator.
// The block takes one live interval word on the input channel (valid/ready)
// and returns one allocation word on the output channel (valid/ready).
// Active intervals sit in a row of cells sorted by end; the row head is
// examined each cycle and the row rotates, so expiry visits each active
// entry in turn and the victim search makes a further pass over the entries.
// A new-function word first passes through a clear state that empties the row
// and resets the stacks and masks. After the result is accepted the block
// returns to idle and only then takes the next word. After reset the free
// stacks hold all pool slots with slot 0 on top and the row is empty. The
// result sits in an output register until taken; while the receiver stalls
// no new word is taken.
`default_nettype none
module linear_scan_register_allocator
  import lsra_pkg::*;
#(
  parameter int INT_POOL_SIZE      = INT_POOL_SIZE_D,
  parameter int FLOAT_POOL_SIZE    = FLOAT_POOL_SIZE_D,
  parameter int INT_CALLEE_FIRST   = INT_CALLEE_FIRST_D,
  parameter int FLOAT_CALLEE_FIRST = FLOAT_CALLEE_FIRST_D,
  parameter int ACTIVE_DEPTH       = ACTIVE_DEPTH_D
)(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              new_function,
  input  wire logic [ID_W-1:0]   interval_id,
  input  wire logic [PT_W-1:0]   live_start,
  input  wire logic [PT_W-1:0]   live_end,
  input  wire logic              reg_class,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   assigned,
  output logic [SLOT_W-1:0]      pool_slot,
  output logic                   evicted,
  output logic [ID_W-1:0]        evicted_id,
  output logic [MASK_W-1:0]      callee_mask,
  output logic [MASK_W-1:0]      caller_mask
);
  localparam int CW = $clog2(ACTIVE_DEPTH + 1);
  localparam int IW = $clog2(INT_POOL_SIZE + 1);
  localparam int FW = $clog2(FLOAT_POOL_SIZE + 1);

  state_t state, state_next;
  logic [ID_W-1:0] cur_id;
  logic [PT_W-1:0] cur_start, cur_end;
  logic            cur_cls;
  logic [CW-1:0]   cnt, left, vpos, vidx;
  logic [PT_W-1:0] vend;
  logic            vfound;
  logic [SLOT_W-1:0] int_stk [INT_POOL_SIZE];
  logic [SLOT_W-1:0] flt_stk [FLOAT_POOL_SIZE];
  logic [IW-1:0]   int_cnt;
  logic [FW-1:0]   flt_cnt;
  logic [MASK_W-1:0] callee_used, caller_used;
  entry_t          keep_head;

  logic      valid_a [ACTIVE_DEPTH];
  entry_t    ent_a   [ACTIVE_DEPTH];
  cell_cmd_t cmd;
  logic      rotate;
  logic      del_a   [ACTIVE_DEPTH];

  // Rotation: head is appended at the tail (or dropped) while the row shifts.
  logic   tail_keep;
  entry_t tail_ent;

  genvar g;
  generate
    for (g = 0; g < ACTIVE_DEPTH; g++) begin : g_cell
      logic   nv, pv;
      entry_t ne, pe;
      if (g == ACTIVE_DEPTH - 1) begin : g_tail
        assign nv = 1'b0;
        assign ne = tail_ent;
      end else begin : g_mid
        assign nv = valid_a[g+1];
        assign ne = ent_a[g+1];
      end
      if (g == 0) begin : g_head
        assign pv = 1'b0;
        assign pe = ent_a[0];
      end else begin : g_body
        assign pv = valid_a[g-1];
        assign pe = ent_a[g-1];
      end
      // During rotation the last valid cell receives the recirculated head.
      logic   rv;
      entry_t re;
      assign rv = nv || (tail_keep && valid_a[g] && !nv);
      assign re = (nv) ? ne : tail_ent;
      cell_cmd_t c;
      assign c = cmd;
      assign del_a[g] = (CW'(g) >= vidx);
      lsra_cell u_cell (
        .clk, .rst, .cmd(c), .is_head(g == 0),
        .prev_valid(pv), .prev_entry(pe),
        .next_valid(rotate ? rv : nv), .next_entry(rotate ? re : ne),
        .del_here(del_a[g]),
        .valid(valid_a[g]), .entry(ent_a[g])
      );
    end
  endgenerate

  logic expire_hit, stack_push_int, stack_push_flt;
  assign keep_head  = ent_a[0];
  assign expire_hit = (ent_a[0].fin < cur_start);
  assign rotate     = (state == ST_EXPIRE) || (state == ST_SEARCH);
  assign tail_keep  = (state == ST_SEARCH) || ((state == ST_EXPIRE) && !expire_hit);
  assign tail_ent   = keep_head;
  assign stack_push_int = (state == ST_EXPIRE) && (left != '0) && expire_hit &&
                          !ent_a[0].cls && (int_cnt < IW'(INT_POOL_SIZE));
  assign stack_push_flt = (state == ST_EXPIRE) && (left != '0) && expire_hit &&
                          ent_a[0].cls && (flt_cnt < FW'(FLOAT_POOL_SIZE));

  logic have_free;
  assign have_free = cur_cls ? (flt_cnt != '0) : (int_cnt != '0);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.ins    = '{id: cur_id, fin: cur_end, cls: cur_cls, slot: pool_slot};
    in_ready   = (state == ST_IDLE);
    case (state)
      ST_IDLE:   if (in_valid) state_next = new_function ? ST_CLEAR : ST_EXPIRE;
      ST_CLEAR: begin
        cmd.clear  = 1'b1;
        state_next = ST_EXPIRE;
      end
      ST_EXPIRE: begin
        if (left == '0) state_next = have_free ? ST_INSERT : ST_SEARCH;
        else cmd.shift = 1'b1;
      end
      ST_SEARCH: begin
        if (left == '0) state_next = ST_EVICT;
        else cmd.shift = 1'b1;
      end
      ST_EVICT: begin
        cmd.evict  = vfound && (vend > cur_end);
        state_next = (vfound && (vend > cur_end)) ? ST_INSERT : ST_OUT;
      end
      ST_INSERT: begin
        cmd.insert = (cnt < CW'(ACTIVE_DEPTH));
        state_next = ST_OUT;
      end
      ST_OUT:    if (out_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  logic [MASK_W-1:0] bit_m;
  logic              callee_side;
  assign bit_m = (pool_slot < SLOT_W'(MASK_W)) ? (MASK_W'(1) << pool_slot) : '0;
  assign callee_side = cur_cls ? (32'(pool_slot) >= FLOAT_CALLEE_FIRST)
                               : (32'(pool_slot) >= INT_CALLEE_FIRST);

  always_ff @(posedge clk) begin
    if (rst || (state == ST_CLEAR)) begin
      int_cnt     <= IW'(INT_POOL_SIZE);
      flt_cnt     <= FW'(FLOAT_POOL_SIZE);
      cnt         <= '0;
      callee_used <= '0;
      caller_used <= '0;
    end else begin
      if (stack_push_int) int_cnt <= int_cnt + 1'b1;
      if (stack_push_flt) flt_cnt <= flt_cnt + 1'b1;
      if ((state == ST_EXPIRE) && (left != '0) && expire_hit) cnt <= cnt - 1'b1;
      if ((state == ST_EXPIRE) && (left == '0) && have_free) begin
        if (cur_cls) flt_cnt <= flt_cnt - 1'b1;
        else         int_cnt <= int_cnt - 1'b1;
      end
      if (cmd.evict) cnt <= cnt - 1'b1;
      if (cmd.insert) cnt <= cnt + 1'b1;
      if (state == ST_INSERT) begin
        if (callee_side) callee_used <= callee_used | bit_m;
        else             caller_used <= caller_used | bit_m;
      end
    end
  end

  // Free stacks reset to slots counting down so that slot 0 is on top.
  always_ff @(posedge clk) begin
    if (rst || (state == ST_CLEAR)) begin
      for (int i = 0; i < INT_POOL_SIZE; i++)
        int_stk[i] <= SLOT_W'(INT_POOL_SIZE - 1 - i);
      for (int i = 0; i < FLOAT_POOL_SIZE; i++)
        flt_stk[i] <= SLOT_W'(FLOAT_POOL_SIZE - 1 - i);
    end else begin
      if (stack_push_int) int_stk[int_cnt] <= ent_a[0].slot;
      if (stack_push_flt) flt_stk[flt_cnt] <= ent_a[0].slot;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: if (in_valid) begin
        cur_id    <= interval_id;
        cur_start <= live_start;
        cur_end   <= live_end;
        cur_cls   <= reg_class;
        assigned  <= 1'b0;
        pool_slot <= '0;
        evicted   <= 1'b0;
        evicted_id <= '0;
        left      <= new_function ? '0 : cnt;
      end
      ST_EXPIRE: begin
        if (left != '0) left <= left - 1'b1;
        else begin
          left   <= cnt;
          vpos   <= '0;
          vidx   <= CW'(ACTIVE_DEPTH);
          vend   <= '0;
          vfound <= 1'b0;
          if (have_free) begin
            assigned  <= 1'b1;
            pool_slot <= cur_cls ? flt_stk[flt_cnt - 1'b1]
                                 : int_stk[int_cnt - 1'b1];
          end
        end
      end
      ST_SEARCH: if (left != '0) begin
        left <= left - 1'b1;
        vpos <= vpos + 1'b1;
        if ((ent_a[0].cls == cur_cls) && (ent_a[0].fin > vend)) begin
          vend       <= ent_a[0].fin;
          vidx       <= vpos;
          vfound     <= 1'b1;
          pool_slot  <= ent_a[0].slot;
          evicted_id <= ent_a[0].id;
        end
      end
      ST_EVICT: begin
        if (cmd.evict) begin
          assigned <= 1'b1;
          evicted  <= 1'b1;
        end else begin
          pool_slot  <= '0;
          evicted_id <= '0;
        end
      end
      default: ;
    endcase
  end

  assign out_valid   = (state == ST_OUT);
  assign callee_mask = callee_used;
  assign caller_mask = caller_used;

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("ready while result pending");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(ACTIVE_DEPTH)) else $error("active count overflow");
  a_evict_assigned: assert property (@(posedge clk) disable iff (rst)
    (out_valid && evicted) |-> assigned) else $error("eviction without assignment");
endmodule
`default_nettype wire

### rtl/lsra_cell.sv
// One cell of the active row: a held entry that shifts towards the head of the row, or towards the tail on insert.
`default_nettype none
module lsra_cell
  import lsra_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cell_cmd_t cmd,
  input  wire logic      is_head,
  input  wire logic      prev_valid,
  input  wire entry_t    prev_entry,
  input  wire logic      next_valid,
  input  wire entry_t    next_entry,
  input  wire logic      del_here,
  output logic           valid,
  output entry_t         entry
);
  // Insert shifts entries with a later end one place towards the tail.
  logic ins_take, ins_here, upper;
  assign ins_take = valid && (entry.fin > cmd.ins.fin);
  assign ins_here = (!valid || ins_take) &&
                    (is_head || (prev_valid && !(prev_entry.fin > cmd.ins.fin)));
  assign upper    = !is_head && prev_valid && (prev_entry.fin > cmd.ins.fin);

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      valid <= 1'b0;
    end else if (cmd.shift || (cmd.evict && del_here)) begin
      valid <= next_valid;
      entry <= next_entry;
    end else if (cmd.insert) begin
      if (upper && (valid || prev_valid)) begin
        valid <= prev_valid;
        entry <= prev_entry;
      end else if (ins_here) begin
        valid <= 1'b1;
        entry <= cmd.ins;
      end
    end
  end
endmodule
`default_nettype wire

### bench/tb_top.sv
// Self-checking testbench for the linear-scan register allocator top level.
`timescale 1ns / 1ps
module tb_top
  import lsra_pkg::*;
();

  typedef struct {
    logic              newfn;
    logic [ID_W-1:0]   id;
    logic [PT_W-1:0]   st;
    logic [PT_W-1:0]   fin;
    logic              cls;
  } interval_t;

  typedef struct {
    logic              assigned;
    logic [SLOT_W-1:0] slot;
    logic              evicted;
    logic [ID_W-1:0]   ev_id;
    logic [MASK_W-1:0] callee;
    logic [MASK_W-1:0] caller;
  } alloc_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, in_ready;
  logic new_function = 1'b0;
  logic [ID_W-1:0] interval_id = '0;
  logic [PT_W-1:0] live_start = '0, live_end = '0;
  logic reg_class = 1'b0;
  logic out_valid, out_ready = 1'b0;
  logic assigned, evicted;
  logic [SLOT_W-1:0] pool_slot;
  logic [ID_W-1:0] evicted_id;
  logic [MASK_W-1:0] callee_mask, caller_mask;

  interval_t pending_words[$];
  alloc_t    expected_allocs[$];
  int n_total = 0, n_accepted = 0, n_results = 0, n_errors = 0;
  int cycles = 0, hold_cnt = 0;
  bit held = 0;

  // Own copy of the allocator state.
  logic [SLOT_W-1:0] int_free[INT_POOL_SIZE_D];
  int                int_cnt;
  logic [SLOT_W-1:0] flt_free[FLOAT_POOL_SIZE_D];
  int                flt_cnt;
  entry_t            live_row[ACTIVE_DEPTH_D];
  int                live_cnt;
  logic [MASK_W-1:0] callee_used, caller_used;

  linear_scan_register_allocator i_dut (.*);

  always #1 clk = ~clk;

  function automatic void clear_allocator();
    int_cnt = 0;
    for (int i = INT_POOL_SIZE_D; i > 0; i--) begin
      int_free[int_cnt] = SLOT_W'(i - 1);
      int_cnt++;
    end
    flt_cnt = 0;
    for (int i = FLOAT_POOL_SIZE_D; i > 0; i--) begin
      flt_free[flt_cnt] = SLOT_W'(i - 1);
      flt_cnt++;
    end
    live_cnt = 0;
    callee_used = '0;
    caller_used = '0;
  endfunction

  function automatic alloc_t allocate(interval_t w);
    alloc_t r;
    int k, victim, vend, pos, first;
    bit found;
    entry_t e;
    r = '{default: '0};
    if (w.newfn) clear_allocator();
    k = 0;
    for (int i = 0; i < live_cnt; i++) begin
      e = live_row[i];
      if (e.fin < w.st) begin
        if (e.cls == 1'b0) begin
          if (int_cnt < INT_POOL_SIZE_D) begin
            int_free[int_cnt] = e.slot;
            int_cnt++;
          end
        end else if (flt_cnt < FLOAT_POOL_SIZE_D) begin
          flt_free[flt_cnt] = e.slot;
          flt_cnt++;
        end
      end else begin
        live_row[k] = e;
        k++;
      end
    end
    live_cnt = k;
    if (w.cls == 1'b0 && int_cnt > 0) begin
      int_cnt--;
      r.slot = int_free[int_cnt];
      r.assigned = 1'b1;
    end else if (w.cls == 1'b1 && flt_cnt > 0) begin
      flt_cnt--;
      r.slot = flt_free[flt_cnt];
      r.assigned = 1'b1;
    end else begin
      vend = 0;
      victim = 0;
      found = 0;
      for (int i = 0; i < live_cnt; i++) begin
        if (live_row[i].cls == w.cls && int'(live_row[i].fin) > vend) begin
          vend = int'(live_row[i].fin);
          victim = i;
          found = 1;
        end
      end
      if (found && vend > int'(w.fin)) begin
        r.slot = live_row[victim].slot;
        r.ev_id = live_row[victim].id;
        r.evicted = 1'b1;
        r.assigned = 1'b1;
        for (int i = victim; i + 1 < live_cnt; i++) live_row[i] = live_row[i + 1];
        live_cnt--;
      end
    end
    if (r.assigned) begin
      if (live_cnt < ACTIVE_DEPTH_D) begin
        pos = live_cnt;
        while (pos > 0 && live_row[pos - 1].fin > w.fin) begin
          live_row[pos] = live_row[pos - 1];
          pos--;
        end
        live_row[pos] = '{id: w.id, fin: w.fin, cls: w.cls, slot: r.slot};
        live_cnt++;
      end
      first = w.cls ? FLOAT_CALLEE_FIRST_D : INT_CALLEE_FIRST_D;
      if (r.slot < MASK_W) begin
        if (int'(r.slot) >= first) callee_used[r.slot] = 1'b1;
        else caller_used[r.slot] = 1'b1;
      end
    end
    r.callee = callee_used;
    r.caller = caller_used;
    return r;
  endfunction

  function automatic int send_idle_pct();
    if (n_accepted < n_total / 3) return 9;
    if (n_accepted < 2 * n_total / 3) return 56;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (n_accepted < n_total / 3) return 56;
    if (n_accepted < 2 * n_total / 3) return 9;
    return 0;
  endfunction

  task automatic queue_word(int nf, int id, int st, int fin, int cls);
    interval_t w;
    w.newfn = nf[0];
    w.id = ID_W'(id);
    w.st = PT_W'(st);
    w.fin = PT_W'(fin);
    w.cls = cls[0];
    pending_words.push_back(w);
  endtask

  // Sender: a word is predicted at the edge where it is accepted.
  always @(posedge clk) begin
    interval_t w;
    logic nv;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      nv = in_valid;
      if (in_valid && in_ready) begin
        w.newfn = new_function;
        w.id = interval_id;
        w.st = live_start;
        w.fin = live_end;
        w.cls = reg_class;
        expected_allocs.push_back(allocate(w));
        n_accepted++;
        nv = 1'b0;
      end
      if (!nv && pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
        w = pending_words.pop_front();
        new_function <= w.newfn;
        interval_id <= w.id;
        live_start <= w.st;
        live_end <= w.fin;
        reg_class <= w.cls;
        nv = 1'b1;
      end
      in_valid <= nv;
    end
  end

  // Receiver readiness, with one long hold-off to fill the block.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else if (!held && n_results >= 150) begin
      held = 1;
      hold_cnt = 400;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct());
    end
  end

  always @(posedge clk) begin
    alloc_t e;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (expected_allocs.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("Unexpected result word at cycle %0d", cycles);
      end else begin
        e = expected_allocs.pop_front();
        if (assigned !== e.assigned || pool_slot !== e.slot || evicted !== e.evicted ||
            evicted_id !== e.ev_id || callee_mask !== e.callee ||
            caller_mask !== e.caller) begin
          n_errors++;
          if (n_errors <= 10)
            $display("Mismatch on word %0d: exp %b %0d %b %0d %h %h got %b %0d %b %0d %h %h",
                     n_results, e.assigned, e.slot, e.evicted, e.ev_id, e.callee,
                     e.caller, assigned, pool_slot, evicted, evicted_id, callee_mask,
                     caller_mask);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= 1000000) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int cur, len, fin;
    clear_allocator();
    // Directed words: field extremes, both classes, zero ends, an inverted interval.
    queue_word(0, 0, 0, 0, 0);
    queue_word(0, 4095, 0, 65535, 1);
    queue_word(0, 1, 0, 0, 1);
    queue_word(0, 2, 65535, 65535, 0);
    queue_word(1, 3, 500, 100, 0);
    queue_word(0, 4, 600, 700, 1);
    queue_word(0, 2730, 21845, 43690, 0);
    queue_word(0, 1365, 43690, 21845, 1);
    queue_word(1, 4095, 65535, 0, 1);
    queue_word(0, 0, 0, 65535, 0);
    while (pending_words.size() < 1360) begin
      cur = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 60000) : $urandom_range(0, 100);
      len = $urandom_range(10, 80);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 19) == 0) begin
          queue_word($urandom_range(0, 1), $urandom_range(0, 4095), $urandom_range(0, 65535),
                     $urandom_range(0, 65535), $urandom_range(0, 1));
        end else begin
          cur = cur + $urandom_range(0, 3);
          if (cur > 65535) cur = 65535;
          fin = cur + (($urandom_range(0, 1) == 0) ? $urandom_range(0, 40)
                                                    : $urandom_range(0, 2000));
          if (fin > 65535) fin = 65535;
          queue_word(int'(i == 0), $urandom_range(0, 4095), cur, fin, $urandom_range(0, 1));
        end
      end
    end
    n_total = pending_words.size();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    wait (pending_words.size() == 0 && !in_valid && expected_allocs.size() == 0);
    repeat (200) @(posedge clk);
    if (n_errors == 0 && expected_allocs.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
